/* rtl/kmp_sr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the streaming search-and-replace block.
package kmp_sr_pkg;

   localparam int PAT_BYTES = 16;
   localparam int REP_BYTES = 32;

   // Configuration register indexes.
   localparam logic [3:0] REG_PAT_LOW  = 4'd0;
   localparam logic [3:0] REG_PAT_HIGH = 4'd1;
   localparam logic [3:0] REG_PAT_LEN  = 4'd2;
   localparam logic [3:0] REG_REP_W0   = 4'd3;
   localparam logic [3:0] REG_REP_W1   = 4'd4;
   localparam logic [3:0] REG_REP_W2   = 4'd5;
   localparam logic [3:0] REG_REP_W3   = 4'd6;
   localparam logic [3:0] REG_REP_LEN  = 4'd7;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       output_end;
   } rsp_type;

   // Failure table entry: a pattern position, or none.
   typedef struct packed {
      logic       none;
      logic [3:0] pos;
   } ft_entry_type;

   // Settings seen by the back end.
   typedef struct packed {
      logic [PAT_BYTES-1:0][7:0] pat;
      logic [REP_BYTES-1:0][7:0] rep;
      logic [4:0]                plen;
      logic [5:0]                rlen;
      logic                      building;
      logic                      clear_match;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_REL,
      ST_REP,
      ST_FIN,
      ST_FLUSH,
      ST_MARK,
      ST_DONE
   } eng_state_type;

endpackage

/* rtl/kmp_sr_fifo.sv */
`timescale 1ns / 1ps
// Two-entry queue used on the input and result sides.
module kmp_sr_fifo #(
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);
   item_type   mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ff];

   // Pointer and count update.
   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end
endmodule

/* rtl/kmp_sr_csr.sv */
`timescale 1ns / 1ps
// Configuration registers and the sequential failure table builder.
module kmp_sr_csr #(
   parameter int PATTERN_MAX = 16,
   parameter int REPLACE_MAX = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [3:0]             csr_index,
   input  logic [63:0]            csr_data,
   input  logic [3:0]             ft_addr,
   output kmp_sr_pkg::ft_entry_type ft_data,
   output kmp_sr_pkg::cfg_type    cfg
);
   import kmp_sr_pkg::*;

   localparam int PLIM = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
   localparam int RLIM = (REPLACE_MAX < REP_BYTES) ? REPLACE_MAX : REP_BYTES;

   logic [1:0][63:0] pat_ff;
   logic [3:0][63:0] rep_ff;
   logic [4:0]       plen_reg_ff;
   logic [5:0]       rlen_reg_ff;
   logic             wr;
   logic             pat_wr;
   logic [4:0]       plen;
   logic [5:0]       rlen;
   logic [PAT_BYTES-1:0][7:0] pat;

   ft_entry_type ft_ff [PAT_BYTES];
   logic         bld_ff, bld_in;
   logic [3:0]   bi_ff, bi_in;
   logic [3:0]   bj_ff, bj_in;
   logic         bjn_ff, bjn_in;
   logic [3:0]   ni, nj;
   logic         advance;
   logic [3:0]   rd_addr;
   ft_entry_type rd_data;
   ft_entry_type new_entry;
   logic         ft_we;

   assign csr_ready = !bld_ff;
   assign wr        = csr_valid && csr_ready;
   assign pat_wr    = wr && (csr_index == REG_PAT_LOW || csr_index == REG_PAT_HIGH
                             || csr_index == REG_PAT_LEN);
   assign pat       = pat_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff      <= '0;
         rep_ff      <= '0;
         plen_reg_ff <= 5'd1;
         rlen_reg_ff <= 6'd0;
      end else if (wr) begin
         unique case (csr_index)
            REG_PAT_LOW:  pat_ff[0]   <= csr_data;
            REG_PAT_HIGH: pat_ff[1]   <= csr_data;
            REG_PAT_LEN:  plen_reg_ff <= csr_data[4:0];
            REG_REP_W0:   rep_ff[0]   <= csr_data;
            REG_REP_W1:   rep_ff[1]   <= csr_data;
            REG_REP_W2:   rep_ff[2]   <= csr_data;
            REG_REP_W3:   rep_ff[3]   <= csr_data;
            REG_REP_LEN:  rlen_reg_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // Length saturation: zero pattern length counts as one.
   always_comb begin
      plen = (plen_reg_ff == 5'd0) ? 5'd1 : plen_reg_ff;
      if (plen > 5'(PLIM)) plen = 5'(PLIM);
      rlen = (rlen_reg_ff > 6'(RLIM)) ? 6'(RLIM) : rlen_reg_ff;
   end

   // One builder iteration per cycle while the loop condition holds.
   always_comb begin
      ni        = bi_ff + 4'd1;
      nj        = bjn_ff ? 4'd0 : bj_ff + 4'd1;
      advance   = bjn_ff || (pat[bi_ff] == pat[bj_ff]);
      rd_addr   = bld_ff ? (advance ? nj : bj_ff) : ft_addr;
      rd_data   = ft_ff[rd_addr];
      new_entry = (pat[ni] != pat[nj]) ? ft_entry_type'{none: 1'b0, pos: nj} : rd_data;
      ft_we     = 1'b0;
      bld_in    = bld_ff;
      bi_in     = bi_ff;
      bj_in     = bj_ff;
      bjn_in    = bjn_ff;
      if (pat_wr) begin
         bld_in = 1'b1;
         bi_in  = 4'd0;
         bjn_in = 1'b1;
      end else if (bld_ff) begin
         if ({1'b0, bi_ff} + 5'd1 >= plen) begin
            bld_in = 1'b0;
         end else if (advance) begin
            ft_we  = 1'b1;
            bi_in  = ni;
            bj_in  = nj;
            bjn_in = 1'b0;
         end else begin
            bj_in  = rd_data.pos;
            bjn_in = rd_data.none;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bld_ff <= 1'b0;
         bjn_ff <= 1'b1;
      end else begin
         bld_ff <= bld_in;
         bjn_ff <= bjn_in;
      end
      bi_ff <= bi_in;
      bj_ff <= bj_in;
   end

   // Table entries: cleared at once when a rebuild starts.
   always_ff @(posedge clock) begin
      if (reset || pat_wr) begin
         for (int k = 0; k < PAT_BYTES; k++) begin
            ft_ff[k] <= '{none: 1'b1, pos: 4'd0};
         end
      end else if (ft_we) begin
         ft_ff[ni] <= new_entry;
      end
   end

   assign ft_data = rd_data;

   always_comb begin
      cfg.pat         = pat;
      cfg.rep         = rep_ff;
      cfg.plen        = plen;
      cfg.rlen        = rlen;
      cfg.building    = bld_ff;
      cfg.clear_match = pat_wr;
   end
endmodule

/* rtl/kmp_sr_engine.sv */
`timescale 1ns / 1ps
// Back end: walks the match for one text byte and emits result transfers.
module kmp_sr_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  kmp_sr_pkg::cfg_type      cfg,
   output logic [3:0]               ft_addr,
   input  kmp_sr_pkg::ft_entry_type ft_data,
   input  logic                     in_empty,
   input  kmp_sr_pkg::req_type      in_item,
   output logic                     in_pop,
   input  logic                     out_full,
   output logic                     out_push,
   output kmp_sr_pkg::rsp_type      out_item
);
   import kmp_sr_pkg::*;

   eng_state_type st_ff, st_in;
   logic [7:0]    c_ff, c_in;
   logic          end_ff, end_in;
   logic [3:0]    j_ff, j_in;
   logic          jn_ff, jn_in;
   logic [4:0]    ml_ff, ml_in;
   logic [5:0]    k_ff, k_in;
   logic [4:0]    cnt_ff, cnt_in;
   ft_entry_type  nx_ff, nx_in;
   logic          pv_ff, pv_in;
   rsp_type       pend_ff, pend_in;

   logic          can_emit;
   logic          emit;
   rsp_type       emit_item;
   logic          hit;
   logic          full_match;
   logic [4:0]    keep;
   logic [4:0]    rel_cnt;
   logic [5:0]    k_next;

   assign ft_addr    = j_ff;
   assign can_emit   = !pv_ff || !out_full;
   assign hit        = (c_ff == cfg.pat[j_ff]);
   assign full_match = ({1'b0, j_ff} + 5'd1 >= cfg.plen);
   assign keep       = ft_data.none ? 5'd0 : {1'b0, ft_data.pos};
   assign rel_cnt    = {1'b0, j_ff} - keep;
   assign k_next     = k_ff + 6'd1;

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (!in_empty && !cfg.building) st_in = ST_STEP;
         ST_STEP: begin
            if (jn_ff) begin
               if (can_emit) st_in = ST_FIN;
            end else if (hit) begin
               st_in = (full_match && cfg.rlen != 6'd0) ? ST_REP : ST_FIN;
            end else if (rel_cnt != 5'd0) begin
               st_in = ST_REL;
            end
         end
         ST_REL:   if (can_emit && k_next == {1'b0, cnt_ff}) st_in = ST_STEP;
         ST_REP:   if (can_emit && k_next == cfg.rlen) st_in = ST_FIN;
         ST_FIN: begin
            if (!end_ff)             st_in = ST_DONE;
            else if (ml_ff != 5'd0)  st_in = ST_FLUSH;
            else                     st_in = ST_MARK;
         end
         ST_FLUSH: if (can_emit && k_next == {1'b0, ml_ff}) st_in = ST_MARK;
         ST_MARK:  if (can_emit) st_in = ST_DONE;
         ST_DONE:  if (!pv_ff || !out_full) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      c_in      = c_ff;
      end_in    = end_ff;
      j_in      = j_ff;
      jn_in     = jn_ff;
      ml_in     = ml_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      nx_in     = nx_ff;
      in_pop    = 1'b0;
      emit      = 1'b0;
      emit_item = '0;
      unique case (st_ff)
         ST_IDLE: begin
            if (!in_empty && !cfg.building) begin
               in_pop = 1'b1;
               c_in   = in_item.text_byte;
               end_in = in_item.text_end;
               j_in   = ml_ff[3:0];
               jn_in  = 1'b0;
            end
         end
         ST_STEP: begin
            k_in = 6'd0;
            if (jn_ff) begin
               emit                 = 1'b1;
               emit_item.out_byte   = c_ff;
               emit_item.byte_valid = 1'b1;
               ml_in                = 5'd0;
            end else if (hit) begin
               ml_in = full_match ? 5'd0 : {1'b0, j_ff} + 5'd1;
            end else if (rel_cnt != 5'd0) begin
               cnt_in = rel_cnt;
               nx_in  = ft_data;
            end else begin
               j_in  = ft_data.pos;
               jn_in = ft_data.none;
            end
         end
         ST_REL: begin
            emit                 = 1'b1;
            emit_item.out_byte   = cfg.pat[k_ff[3:0]];
            emit_item.byte_valid = 1'b1;
            if (can_emit) begin
               k_in = k_next;
               if (k_next == {1'b0, cnt_ff}) begin
                  j_in  = nx_ff.pos;
                  jn_in = nx_ff.none;
               end
            end
         end
         ST_REP: begin
            emit                 = 1'b1;
            emit_item.out_byte   = cfg.rep[k_ff[4:0]];
            emit_item.byte_valid = 1'b1;
            if (can_emit) k_in = k_next;
         end
         ST_FIN: k_in = 6'd0;
         ST_FLUSH: begin
            emit                 = 1'b1;
            emit_item.out_byte   = cfg.pat[k_ff[3:0]];
            emit_item.byte_valid = 1'b1;
            if (can_emit) k_in = k_next;
         end
         ST_MARK: begin
            emit                 = 1'b1;
            emit_item.output_end = 1'b1;
            if (can_emit) ml_in = 5'd0;
         end
         ST_DONE: ;
         default: ;
      endcase
      if (cfg.clear_match) ml_in = 5'd0;
   end

   // The newest result is held back until it is known whether it ends its run.
   always_comb begin
      pv_in    = pv_ff;
      pend_in  = pend_ff;
      out_push = 1'b0;
      out_item = pend_ff;
      if (emit && can_emit) begin
         out_push = pv_ff;
         pv_in    = 1'b1;
         pend_in  = emit_item;
      end else if (st_ff == ST_DONE && pv_ff && !out_full) begin
         out_push          = 1'b1;
         out_item.run_last = 1'b1;
         pv_in             = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ml_ff <= 5'd0;
         pv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ml_ff <= ml_in;
         pv_ff <= pv_in;
      end
      c_ff    <= c_in;
      end_ff  <= end_in;
      j_ff    <= j_in;
      jn_ff   <= jn_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      nx_ff   <= nx_in;
      pend_ff <= pend_in;
   end
endmodule

/* rtl/kmp_stream_replace_core.sv */
`timescale 1ns / 1ps
// Streaming search-and-replace: front queue, configuration and table builder, back end.
// The back end takes a new input byte only after it is through with the previous one, including
// any fallback steps, released bytes, replacement bytes and flush bytes for it;
// its state machine emits one result per cycle while the result queue is not full.
// Reset is synchronous: registers return to their defaults and the table holds no entries.
// A pattern write rebuilds the table, during which csr_ready is low.
module kmp_stream_replace_core #(
   parameter int PATTERN_MAX = 16,
   parameter int REPLACE_MAX = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  kmp_sr_pkg::req_type req_item,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output kmp_sr_pkg::rsp_type rsp_item,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_index,
   input  logic [63:0]         csr_data
);
   import kmp_sr_pkg::*;

   cfg_type      cfg;
   logic [3:0]   ft_addr;
   ft_entry_type ft_data;
   logic         in_empty;
   req_type      in_item;
   logic         in_pop;
   logic         out_full;
   logic         out_push;
   rsp_type      out_item;

   // Front queue for incoming text bytes.
   kmp_sr_fifo #(.item_type(req_type)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (req_item),
      .full      (req_full),
      .pop       (in_pop),
      .pop_item  (in_item),
      .empty     (in_empty)
   );

   kmp_sr_csr #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ft_addr   (ft_addr),
      .ft_data   (ft_data),
      .cfg       (cfg)
   );

   kmp_sr_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .ft_addr  (ft_addr),
      .ft_data  (ft_data),
      .in_empty (in_empty),
      .in_item  (in_item),
      .in_pop   (in_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_item (out_item)
   );

   // Result queue toward the consumer.
   kmp_sr_fifo #(.item_type(rsp_type)) u_result (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_item (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_item),
      .empty     (rsp_empty)
   );
endmodule

/* verif/kmp_sr_checker.sv */
`timescale 1ns / 1ps
// Checker for the search-and-replace block: watches all channels, predicts and compares.
module kmp_sr_checker
   import kmp_sr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  req_type     req_item,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  rsp_type     rsp_item,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending
);

   // Shadow of the configuration and the matcher state.
   logic [63:0] pat_words [2];
   logic [63:0] rep_words [4];
   logic [4:0]  pat_len_raw;
   logic [5:0]  rep_len_raw;
   logic [7:0]  pat_bytes [PAT_BYTES];
   int          pat_len;
   int          rep_len;
   int          fallback [PAT_BYTES];
   int          held_len;
   rsp_type     rewritten_q [$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic void clamp_lengths();
      pat_len = (pat_len_raw < 1) ? 1 : (pat_len_raw > 16) ? 16 : int'(pat_len_raw);
      rep_len = (rep_len_raw > 32) ? 32 : int'(rep_len_raw);
   endfunction

   // Rebuild the optimized failure table from the pattern; held bytes are dropped.
   function automatic void rebuild_table();
      int i;
      int j;
      clamp_lengths();
      for (int k = 0; k < PAT_BYTES; k++) begin
         pat_bytes[k] = pat_words[k / 8][(k % 8) * 8 +: 8];
         fallback[k] = -1;
      end
      i = 0;
      j = -1;
      while (i < pat_len - 1) begin
         if (j < 0 || pat_bytes[i] == pat_bytes[j]) begin
            i++;
            j++;
            fallback[i] = (pat_bytes[i] != pat_bytes[j]) ? j : fallback[j];
         end else begin
            j = fallback[j];
         end
      end
      held_len = 0;
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      rsp_type r;
      r.out_byte = b;
      r.byte_valid = 1'b1;
      r.run_last = 1'b0;
      r.output_end = 1'b0;
      rewritten_q.push_back(r);
   endfunction

   // Work out the rewritten bytes caused by one text byte.
   function automatic void rewrite_text(input req_type t);
      int j;
      int keep;
      int first;
      rsp_type r;
      first = rewritten_q.size();
      j = held_len;
      forever begin
         if (j < 0) begin
            add_byte(t.text_byte);
            held_len = 0;
            break;
         end
         if (t.text_byte == pat_bytes[j]) begin
            j++;
            if (j >= pat_len) begin
               for (int k = 0; k < rep_len; k++)
                  add_byte(rep_words[k / 8][(k % 8) * 8 +: 8]);
               held_len = 0;
            end else begin
               held_len = j;
            end
            break;
         end
         // Mismatch: release the oldest held bytes that fall out of the match.
         keep = (fallback[j] < 0) ? 0 : fallback[j];
         for (int k = 0; k < j - keep; k++)
            add_byte(pat_bytes[k]);
         j = fallback[j];
      end
      if (t.text_end) begin
         for (int k = 0; k < held_len; k++)
            add_byte(pat_bytes[k]);
         r.out_byte = 8'h00;
         r.byte_valid = 1'b0;
         r.run_last = 1'b0;
         r.output_end = 1'b1;
         rewritten_q.push_back(r);
         held_len = 0;
      end
      if (rewritten_q.size() > first)
         rewritten_q[rewritten_q.size() - 1].run_last = 1'b1;
   endfunction

   function automatic void write_register(input logic [3:0] idx, input logic [63:0] data);
      case (idx)
         REG_PAT_LOW: begin
            pat_words[0] = data;
            rebuild_table();
         end
         REG_PAT_HIGH: begin
            pat_words[1] = data;
            rebuild_table();
         end
         REG_PAT_LEN: begin
            pat_len_raw = data[4:0];
            rebuild_table();
         end
         REG_REP_W0, REG_REP_W1, REG_REP_W2, REG_REP_W3: begin
            rep_words[idx - REG_REP_W0] = data;
         end
         REG_REP_LEN: begin
            rep_len_raw = data[5:0];
            clamp_lengths();
         end
         default: begin
         end
      endcase
   endfunction

   // Follow each transfer at the rising edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pat_words = '{64'd0, 64'd0};
         rep_words = '{64'd0, 64'd0, 64'd0, 64'd0};
         pat_len_raw = 5'd1;
         rep_len_raw = 6'd0;
         rebuild_table();
         rewritten_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready)
            write_register(csr_index, csr_data);
         if (req_push && !req_full)
            rewrite_text(req_item);
         if (rsp_pop && !rsp_empty) begin
            if (rewritten_q.size() == 0) begin
               report_mismatch("unexpected result", int'(rsp_item), 0);
            end else begin
               want = rewritten_q.pop_front();
               if (rsp_item.out_byte !== want.out_byte)
                  report_mismatch("out_byte", int'(rsp_item.out_byte), int'(want.out_byte));
               if (rsp_item.byte_valid !== want.byte_valid)
                  report_mismatch("byte_valid", int'(rsp_item.byte_valid),
                                  int'(want.byte_valid));
               if (rsp_item.run_last !== want.run_last)
                  report_mismatch("run_last", int'(rsp_item.run_last), int'(want.run_last));
               if (rsp_item.output_end !== want.output_end)
                  report_mismatch("output_end", int'(rsp_item.output_end),
                                  int'(want.output_end));
            end
         end
      end
      pending = rewritten_q.size();
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Top of the search-and-replace testbench: clock, reset, stimulus and verdict.
module testbench;
   import kmp_sr_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   req_type     req_item;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_item;
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_index;
   logic [63:0] csr_data;
   int          fail_count;
   int          pending;
   int          quiet_cycles;
   int          pop_stall;
   int          hold_req;
   int          hold_ack;
   logic [7:0]  symbols [3];

   kmp_stream_replace_core u_dut (
      .clock, .reset, .req_push, .req_full, .req_item, .rsp_empty, .rsp_pop, .rsp_item,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   kmp_sr_checker u_checker (
      .clock, .reset, .req_push, .req_full, .req_item, .rsp_empty, .rsp_pop, .rsp_item,
      .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count, .pending
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Gap length: mostly none, some short, a few long.
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one text byte after a gap, holding push until the transfer happens.
   task automatic send_text(input logic [7:0] b, input logic last, input int gap);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_item <= '{text_byte: b, text_end: last};
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   // Write one register; valid stays high until csr_release.
   task automatic csr_write(input logic [3:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic csr_release();
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Stop sending until every expected result has come and the block has settled.
   task automatic drain();
      req_push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [63:0] pick_pattern_word();
      logic [63:0] w;
      for (int k = 0; k < 8; k++)
         w[k * 8 +: 8] = symbols[$urandom_range(0, 2)];
      return w;
   endfunction

   // Result side: pops with random stalls, and one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_req != hold_ack) begin
         rsp_pop <= 1'b0;
         repeat (300) @(negedge clock);
         hold_ack = hold_req;
      end else if (pop_stall > 0) begin
         rsp_pop <= 1'b0;
         pop_stall--;
      end else begin
         rsp_pop <= 1'b1;
         pop_stall = draw_gap();
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int roll;
      logic [7:0] b;
      hold_req = 0;
      reset = 1'b1;
      req_push = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = REG_PAT_LOW;
      csr_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Reset settings: single zero byte pattern deleted from the text.
      send_text(8'h00, 1'b0, 0);
      send_text(8'hFF, 1'b1, 0);
      drain();

      // Pattern "aab" replaced by "XYZ": fallback releases and flush at end.
      csr_write(REG_PAT_LOW, 64'h0000_0000_0062_6161);
      csr_write(REG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_PAT_LEN, 64'd3);
      csr_write(REG_REP_W0, 64'h0000_0000_005A_5958);
      csr_write(REG_REP_LEN, 64'd3);
      csr_write(4'd8, 64'd5);
      csr_write(4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_release();
      send_text(8'h61, 1'b0, 0);
      send_text(8'h61, 1'b0, 0);
      send_text(8'h61, 1'b0, 0);
      send_text(8'h62, 1'b0, 0);
      send_text(8'h61, 1'b0, 0);
      send_text(8'hFF, 1'b0, 0);
      send_text(8'h61, 1'b0, 0);
      send_text(8'h61, 1'b1, 0);
      drain();

      // Zero pattern length acts as one; empty replacement deletes the match.
      csr_write(REG_PAT_LEN, 64'd0);
      csr_write(REG_REP_LEN, 64'd0);
      csr_release();
      send_text(8'h61, 1'b0, 0);
      send_text(8'h00, 1'b1, 0);
      drain();

      // Oversized lengths saturate: 16 byte pattern, 32 byte replacement.
      csr_write(REG_PAT_LOW, 64'h5A5A_5A5A_5A5A_5A5A);
      csr_write(REG_PAT_HIGH, 64'h5A5A_5A5A_5A5A_5A5A);
      csr_write(REG_PAT_LEN, 64'd31);
      csr_write(REG_REP_W1, 64'h0123_4567_89AB_CDEF);
      csr_write(REG_REP_W2, 64'hFEDC_BA98_7654_3210);
      csr_write(REG_REP_W3, 64'h8000_0000_0000_0001);
      csr_write(REG_REP_LEN, 64'd63);
      csr_release();
      for (int k = 0; k < 17; k++)
         send_text(8'h5A, 1'b0, 0);
      drain();

      // Pattern rewritten while a partial match is held: held bytes are dropped.
      csr_write(REG_PAT_LEN, 64'd16);
      csr_release();
      send_text(8'h5A, 1'b1, 0);
      drain();

      // Random phases over small alphabets so that matches and fallbacks are common.
      for (int phase = 0; phase < 12; phase++) begin
         for (int k = 0; k < 3; k++)
            symbols[k] = 8'($urandom_range(0, 255));
         csr_write(REG_PAT_LOW, pick_pattern_word());
         csr_write(REG_PAT_HIGH, pick_pattern_word());
         roll = $urandom_range(0, 9);
         csr_write(REG_PAT_LEN, (roll == 0) ? 64'($urandom_range(0, 31)) :
                   (roll == 1) ? 64'd16 : 64'($urandom_range(1, 5)));
         for (int w = 0; w < 4; w++)
            if ($urandom_range(0, 1))
               csr_write(REG_REP_W0 + 4'(w), {$urandom, $urandom});
         roll = $urandom_range(0, 9);
         csr_write(REG_REP_LEN, (roll == 0) ? 64'($urandom_range(0, 63)) :
                   (roll == 1) ? 64'd32 : 64'($urandom_range(0, 4)));
         csr_release();
         if (phase == 2)
            hold_req++;
         for (int n = 0; n < 25; n++) begin
            b = ($urandom_range(0, 99) < 85) ? symbols[$urandom_range(0, 2)] :
                8'($urandom_range(0, 255));
            send_text(b, ($urandom_range(0, 11) == 0), draw_gap());
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/kmp_sr_pkg.sv
rtl/kmp_sr_fifo.sv
rtl/kmp_sr_csr.sv
rtl/kmp_sr_engine.sv
rtl/kmp_stream_replace_core.sv
verif/kmp_sr_checker.sv
verif/testbench.sv
